@@ rtl/hpd_pkg.sv @@
// ----------------------------------------------------------------------------
// hpd_pkg
// Shared types and constants of the hysteresis peak detector.
// ----------------------------------------------------------------------------
package hpd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int PEAK_POS_W = 12;
    localparam int STATUS_W   = 2;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int OUT_DATA_W = 32;

    localparam logic [STATUS_W-1:0] STATUS_FOUND       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_PEAK     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_THRESH  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG    = 2'd3;

    localparam logic REG_HIGH_THRESHOLD = 1'b0;
    localparam logic REG_LOW_THRESHOLD  = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] HIGH_THRESHOLD_RESET = 16'sd16384;
    localparam logic signed [SAMPLE_W-1:0] LOW_THRESHOLD_RESET  = 16'sd8192;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] high;
        logic signed [SAMPLE_W-1:0] low;
    } hpd_thresh_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] level;
        logic [PEAK_POS_W-1:0]      position;
        logic [STATUS_W-1:0]        status;
    } hpd_result_t;

endpackage

@@ rtl/hysteresis_peak_detector.sv @@
// ----------------------------------------------------------------------------
// hysteresis_peak_detector
// Framed correlation peak detector with hysteresis thresholds.
// ----------------------------------------------------------------------------
// The block takes one signed Q1.15 sample per cycle and gives one result item
// per frame, after its last item passes the input and output registers. Every
// item passes an input register and one pass of compare logic that updates the
// region and best-peak registers, so one item per cycle is sustained; the
// input side stalls only when a last item finds the output register still
// holding an untaken result. Thresholds are written over APB at byte addresses
// 0 (high) and 4 (low) while no item is in flight, a user rule the block does
// not enforce; a change between two items of a frame applies to later items.
module hysteresis_peak_detector #(
    parameter int MAX_FRAME_LEN = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tdata: sample[15:0]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [hpd_pkg::SAMPLE_W-1:0]        s_tdata,
    input  logic                                s_tlast,
    // tdata: status[1:0], peak_position[13:2], peak_level[29:14], zeros[31:30]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [hpd_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hpd_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [hpd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [hpd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import hpd_pkg::*;

    hpd_thresh_t                thresh;
    hpd_result_t                result;
    hpd_result_t                out_data_reg;
    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] in_sample_reg;
    logic                       in_last_reg;
    logic                       out_valid_reg;
    logic                       out_free;
    logic                       proc_fire;

    hpd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .thresh  (thresh)
    );

    assign out_free  = !out_valid_reg || m_tready;
    assign proc_fire = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready  = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_sample_reg <= s_tdata;
            in_last_reg   <= s_tlast;
        end
    end

    hpd_core #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (proc_fire),
        .sample    (in_sample_reg),
        .frame_end (in_last_reg),
        .thresh    (thresh),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && in_last_reg) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_data_reg);

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(proc_fire && in_last_reg))
        else $error("result appeared without a processed last item");

    a_found_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.status == STATUS_FOUND)
            |-> (out_data_reg.level > 0))
        else $error("found peak is not above zero");

    a_no_peak_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.status != STATUS_FOUND)
            |-> (out_data_reg.level == 0 && out_data_reg.position == 0))
        else $error("peak fields not zero without a found peak");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && in_last_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

endmodule

@@ rtl/hpd_cfg.sv @@
// ----------------------------------------------------------------------------
// hpd_cfg
// APB register file holding the high and low thresholds.
// ----------------------------------------------------------------------------
module hpd_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hpd_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [hpd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [hpd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output hpd_pkg::hpd_thresh_t                thresh
);
    import hpd_pkg::*;

    logic signed [SAMPLE_W-1:0] high_reg;
    logic signed [SAMPLE_W-1:0] low_reg;
    logic                       wr_en;
    logic                       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_reg <= HIGH_THRESHOLD_RESET;
            low_reg  <= LOW_THRESHOLD_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_HIGH_THRESHOLD: high_reg <= pwdata[SAMPLE_W-1:0];
                REG_LOW_THRESHOLD:  low_reg  <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_HIGH_THRESHOLD: prdata = APB_DATA_W'(high_reg);
            REG_LOW_THRESHOLD:  prdata = APB_DATA_W'(low_reg);
            default:            prdata = '0;
        endcase
    end

    assign thresh.high = high_reg;
    assign thresh.low  = low_reg;

endmodule

@@ rtl/hpd_core.sv @@
// ----------------------------------------------------------------------------
// hpd_core
// Region tracking, best peak selection and frame-end status in one pass.
// ----------------------------------------------------------------------------
module hpd_core #(
    parameter int MAX_FRAME_LEN = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                fire,
    input  logic signed [hpd_pkg::SAMPLE_W-1:0] sample,
    input  logic                                frame_end,
    input  hpd_pkg::hpd_thresh_t                thresh,
    output hpd_pkg::hpd_result_t                result
);
    import hpd_pkg::*;

    localparam int POS_W = (MAX_FRAME_LEN > 2) ? $clog2(MAX_FRAME_LEN) : 1;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_LEN - 1);

    logic                       in_region_reg,  in_region_next;
    logic signed [SAMPLE_W-1:0] region_max_reg, region_max_next;
    logic [POS_W-1:0]           region_pos_reg, region_pos_next;
    logic signed [SAMPLE_W-1:0] best_level_reg, best_level_next;
    logic [POS_W-1:0]           best_pos_reg,   best_pos_next;
    logic                       best_found_reg, best_found_next;
    logic [POS_W-1:0]           sample_pos_reg, sample_pos_next;
    logic                       overflow_reg,   overflow_next;

    logic                       region_upd;
    logic                       region_close;
    logic                       do_offer;
    logic                       take_best;
    logic [POS_W+PEAK_POS_W-1:0] pos_wide;

    always_comb begin
        region_upd   = in_region_reg ? (sample > region_max_reg) : (sample > thresh.high);
        region_close = in_region_reg && (sample < thresh.low);

        region_max_next = region_upd ? sample : region_max_reg;
        region_pos_next = region_upd ? sample_pos_reg : region_pos_reg;
        in_region_next  = in_region_reg ? !region_close : region_upd;

        do_offer  = region_close || (frame_end && in_region_next);
        take_best = do_offer && (region_max_next > best_level_reg);

        best_level_next = take_best ? region_max_next : best_level_reg;
        best_pos_next   = take_best ? region_pos_next : best_pos_reg;
        best_found_next = best_found_reg || take_best;

        if (sample_pos_reg >= POS_MAX) begin
            sample_pos_next = sample_pos_reg;
            overflow_next   = 1'b1;
        end else begin
            sample_pos_next = sample_pos_reg + 1'b1;
            overflow_next   = overflow_reg;
        end

        pos_wide = {{PEAK_POS_W{1'b0}}, best_pos_next};

        result.position = '0;
        result.level    = '0;
        if (thresh.high < thresh.low) begin
            result.status = STATUS_BAD_THRESH;
        end else if (overflow_reg) begin
            result.status = STATUS_TOO_LONG;
        end else if (best_found_next) begin
            result.status   = STATUS_FOUND;
            result.position = pos_wide[PEAK_POS_W-1:0];
            result.level    = best_level_next;
        end else begin
            result.status = STATUS_NO_PEAK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && frame_end)) begin
            in_region_reg  <= 1'b0;
            region_max_reg <= '0;
            region_pos_reg <= '0;
            best_level_reg <= '0;
            best_pos_reg   <= '0;
            best_found_reg <= 1'b0;
            sample_pos_reg <= '0;
            overflow_reg   <= 1'b0;
        end else if (fire) begin
            in_region_reg  <= in_region_next;
            region_max_reg <= region_max_next;
            region_pos_reg <= region_pos_next;
            best_level_reg <= best_level_next;
            best_pos_reg   <= best_pos_next;
            best_found_reg <= best_found_next;
            sample_pos_reg <= sample_pos_next;
            overflow_reg   <= overflow_next;
        end
    end

endmodule
